[rtl/core/assert_macros.svh]
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ascon_pkg.sv]
package ascon_pkg;

	localparam int LANE_W     = 64;
	localparam int NUM_LANES  = 5;
	localparam int CNT_W      = 4;
	localparam int ROUND_W    = 4;
	localparam int IN_TDATA_W = 328;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_IDX_W  = 2;

	localparam logic [LANE_W-1:0] LANE_IV = 64'h80400c0600000000;

	// round numbers: a full permutation starts at 0, a block permutation at 6
	localparam logic [ROUND_W-1:0] ROUND_FIRST_FULL  = 4'd0;
	localparam logic [ROUND_W-1:0] ROUND_FIRST_BLOCK = 4'd6;
	localparam logic [ROUND_W-1:0] ROUND_LAST        = 4'd11;

	localparam logic [CNT_W-1:0] FULL_BYTES = 4'd8;

	typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_BLOCK = 2'd1,
		OP_END   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_BLOCK  = 2'd0,
		KIND_TAG    = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LO  = 2'd0,
		CFG_KEY_HI  = 2'd1,
		CFG_DECRYPT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OUT_NONE,
		OUT_BLOCK,
		OUT_TAG_LO,
		OUT_TAG_HI,
		OUT_STATUS
	} out_sel_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic               load_init;
		logic               absorb;
		logic               key_pre;
		logic               round_en;
		logic               key_post;
		logic [ROUND_W-1:0] round_idx;
		out_sel_t           out_sel;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic decrypt_mode;
	} dp_status_t;

	function automatic logic [LANE_W-1:0] rotr(logic [LANE_W-1:0] x, int n);
		return (x >> n) | (x << (LANE_W - n));
	endfunction

	// one permutation round with its round constant
	function automatic lanes_t ascon_round(lanes_t s_in, logic [ROUND_W-1:0] r);
		lanes_t s;
		lanes_t t;
		logic [7:0] rc;
		s = s_in;
		rc = {4'(4'hf - r), r};
		s[2] = s[2] ^ {56'd0, rc};
		s[0] = s[0] ^ s[4];
		s[4] = s[4] ^ s[3];
		s[2] = s[2] ^ s[1];
		t[0] = ~s[0] & s[1];
		t[1] = ~s[1] & s[2];
		t[2] = ~s[2] & s[3];
		t[3] = ~s[3] & s[4];
		t[4] = ~s[4] & s[0];
		s[0] = s[0] ^ t[1];
		s[1] = s[1] ^ t[2];
		s[2] = s[2] ^ t[3];
		s[3] = s[3] ^ t[4];
		s[4] = s[4] ^ t[0];
		s[1] = s[1] ^ s[0];
		s[0] = s[0] ^ s[4];
		s[3] = s[3] ^ s[2];
		s[2] = ~s[2];
		s[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
		s[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
		s[2] = s[2] ^ rotr(s[2], 1) ^ rotr(s[2], 6);
		s[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
		s[4] = s[4] ^ rotr(s[4], 7) ^ rotr(s[4], 41);
		return s;
	endfunction

endpackage

[rtl/core/ascon_aead_stream_cipher_top.sv]
// begin word: load and 12 rounds, one round a cycle, no result
// block word: absorb and the block rounds; its result sits in the output register in the cycle after acceptance
// end word: 12 rounds, then tag words one a cycle while the output is free (two on encrypt, one status on decrypt)
// ignored words are accepted and leave the state as it is; throughput is set by the single round unit
// arst_n clears the cipher state, the key, the mode, the open flag and the output valid
module ascon_aead_stream_cipher_top
	import ascon_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LANE_W-1:0]      cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// data, byte_count, nonce_lo, nonce_hi, tag_lo, tag_hi, zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// data_out, valid_bytes_out, auth_ok, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// kind
	output logic [1:0]             m_axis_tuser,
	output logic                   m_axis_tlast
);

	dp_cmd_t           cmd;
	dp_status_t        status;
	logic [LANE_W-1:0] data_out;
	logic [CNT_W-1:0]  vbytes;
	logic              auth_ok;

	ascon_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.item_ready (s_axis_tready),
		.op         (s_axis_tuser),
		.byte_count (s_axis_tdata[67:64]),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.status     (status),
		.cmd        (cmd)
	);

	ascon_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.data            (s_axis_tdata[63:0]),
		.byte_count      (s_axis_tdata[67:64]),
		.nonce_lo        (s_axis_tdata[131:68]),
		.nonce_hi        (s_axis_tdata[195:132]),
		.tag_lo          (s_axis_tdata[259:196]),
		.tag_hi          (s_axis_tdata[323:260]),
		.status          (status),
		.data_out        (data_out),
		.valid_bytes_out (vbytes),
		.kind            (m_axis_tuser),
		.auth_ok         (auth_ok),
		.last            (m_axis_tlast)
	);

	// pack the result word
	assign m_axis_tdata = {3'b000, auth_ok, vbytes, data_out};

endmodule

[rtl/core/ascon_datapath.sv]
module ascon_datapath
	import ascon_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LANE_W-1:0]    cfg_data,
	input  dp_cmd_t              cmd,
	input  logic [LANE_W-1:0]    data,
	input  logic [CNT_W-1:0]     byte_count,
	input  logic [LANE_W-1:0]    nonce_lo,
	input  logic [LANE_W-1:0]    nonce_hi,
	input  logic [LANE_W-1:0]    tag_lo,
	input  logic [LANE_W-1:0]    tag_hi,
	output dp_status_t           status,
	output logic [LANE_W-1:0]    data_out,
	output logic [CNT_W-1:0]     valid_bytes_out,
	output logic [1:0]           kind,
	output logic                 auth_ok,
	output logic                 last
);

	logic [LANE_W-1:0] key_lo_q;
	logic [LANE_W-1:0] key_hi_q;
	logic              decrypt_q;
	lanes_t            lanes_q;
	logic [LANE_W-1:0] exp_lo_q;
	logic [LANE_W-1:0] exp_hi_q;
	logic [LANE_W-1:0] data_out_q;
	logic [CNT_W-1:0]  vbytes_q;
	kind_t             kind_q;
	logic              auth_q;
	logic              last_q;

	logic [CNT_W-1:0]  cnt_sat;
	logic [LANE_W-1:0] mask;
	logic [LANE_W-1:0] blk_res;
	logic [LANE_W-1:0] blk_ct;
	lanes_t            pre;
	lanes_t            rnd;
	lanes_t            lanes_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			decrypt_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_LO:  key_lo_q  <= cfg_data;
				CFG_KEY_HI:  key_hi_q  <= cfg_data;
				CFG_DECRYPT: decrypt_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	assign status.decrypt_mode = decrypt_q;

	// byte mask of the block, count saturated to a full word
	always_comb begin
		cnt_sat = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
		for (int i = 0; i < LANE_W / 8; i++) begin
			mask[8*i +: 8] = {8{CNT_W'(i) < cnt_sat}};
		end
		blk_res = (data ^ lanes_q[0]) & mask;
		blk_ct  = decrypt_q ? (data & mask) : blk_res;
	end

	// state ahead of the round (load, absorb or key mix), then the round and the closing key mix
	always_comb begin
		pre = lanes_q;
		if (cmd.load_init) begin
			pre[0] = LANE_IV;
			pre[1] = key_lo_q;
			pre[2] = key_hi_q;
			pre[3] = nonce_lo;
			pre[4] = nonce_hi;
		end else if (cmd.absorb) begin
			pre[0] = (lanes_q[0] & ~mask) | blk_ct;
		end else if (cmd.key_pre) begin
			pre[1] = lanes_q[1] ^ key_lo_q;
			pre[2] = lanes_q[2] ^ key_hi_q;
		end
		rnd = ascon_round(pre, cmd.round_idx);
		lanes_nxt = cmd.round_en ? rnd : pre;
		if (cmd.key_post) begin
			lanes_nxt[3] = lanes_nxt[3] ^ key_lo_q;
			lanes_nxt[4] = lanes_nxt[4] ^ key_hi_q;
		end
	end

	// cipher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q <= '0;
		end else begin
			lanes_q <= lanes_nxt;
		end
	end

	// expected tag, held from the end word until the check
	always_ff @(posedge clk) begin
		if (cmd.key_pre) begin
			exp_lo_q <= tag_lo;
			exp_hi_q <= tag_hi;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			OUT_BLOCK: begin
				data_out_q <= blk_res;
				vbytes_q   <= cnt_sat;
				kind_q     <= KIND_BLOCK;
				auth_q     <= 1'b0;
				last_q     <= 1'b1;
			end
			OUT_TAG_LO: begin
				data_out_q <= lanes_q[3];
				vbytes_q   <= FULL_BYTES;
				kind_q     <= KIND_TAG;
				auth_q     <= 1'b0;
				last_q     <= 1'b0;
			end
			OUT_TAG_HI: begin
				data_out_q <= lanes_q[4];
				vbytes_q   <= FULL_BYTES;
				kind_q     <= KIND_TAG;
				auth_q     <= 1'b0;
				last_q     <= 1'b1;
			end
			OUT_STATUS: begin
				data_out_q <= '0;
				vbytes_q   <= '0;
				kind_q     <= KIND_STATUS;
				auth_q     <= (exp_lo_q == lanes_q[3]) && (exp_hi_q == lanes_q[4]);
				last_q     <= 1'b1;
			end
			default: ;
		endcase
	end

	assign data_out        = data_out_q;
	assign valid_bytes_out = vbytes_q;
	assign kind            = kind_q;
	assign auth_ok         = auth_q;
	assign last            = last_q;

endmodule

[rtl/core/ascon_ctrl.sv]
`include "assert_macros.svh"

module ascon_ctrl
	import ascon_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic [1:0]       op,
	input  logic [CNT_W-1:0] byte_count,
	output logic             res_valid,
	input  logic             res_ready,
	input  dp_status_t       status,
	output dp_cmd_t          cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT1,
		ST_EMIT2
	} state_t;

	typedef enum logic [1:0] {
		RUN_INIT,
		RUN_BLOCK,
		RUN_FINAL
	} run_t;

	state_t             state_q;
	run_t               run_q;
	logic [ROUND_W-1:0] round_q;
	logic               open_q;
	logic               out_vld_q;

	logic   out_free;
	logic   accept;
	op_t    op_in;
	state_t state_nxt;
	run_t   run_nxt;
	logic [ROUND_W-1:0] round_nxt;
	logic   open_nxt;

	assign op_in      = op_t'(op);
	assign out_free   = !out_vld_q || res_ready;
	assign item_ready = (state_q == ST_IDLE) && out_free;
	assign accept     = item_valid && item_ready;
	assign res_valid  = out_vld_q;

	// command decode and next state
	always_comb begin
		cmd       = '0;
		cmd.out_sel = OUT_NONE;
		state_nxt = state_q;
		run_nxt   = run_q;
		round_nxt = round_q;
		open_nxt  = open_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_in)
						OP_BEGIN: begin
							cmd.load_init = 1'b1;
							cmd.round_en  = 1'b1;
							cmd.round_idx = ROUND_FIRST_FULL;
							round_nxt     = ROUND_FIRST_FULL + 4'd1;
							run_nxt       = RUN_INIT;
							state_nxt     = ST_RUN;
							open_nxt      = 1'b1;
						end
						OP_BLOCK: begin
							if (open_q && (byte_count != '0)) begin
								cmd.absorb    = 1'b1;
								cmd.round_en  = 1'b1;
								cmd.round_idx = ROUND_FIRST_BLOCK;
								cmd.out_sel   = OUT_BLOCK;
								round_nxt     = ROUND_FIRST_BLOCK + 4'd1;
								run_nxt       = RUN_BLOCK;
								state_nxt     = ST_RUN;
							end
						end
						OP_END: begin
							if (open_q) begin
								cmd.key_pre   = 1'b1;
								cmd.round_en  = 1'b1;
								cmd.round_idx = ROUND_FIRST_FULL;
								round_nxt     = ROUND_FIRST_FULL + 4'd1;
								run_nxt       = RUN_FINAL;
								state_nxt     = ST_RUN;
								open_nxt      = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				cmd.round_en  = 1'b1;
				cmd.round_idx = round_q;
				round_nxt     = round_q + 4'd1;
				if (round_q == ROUND_LAST) begin
					cmd.key_post = (run_q != RUN_BLOCK);
					state_nxt    = (run_q == RUN_FINAL) ? ST_EMIT1 : ST_IDLE;
				end
			end
			ST_EMIT1: begin
				if (out_free) begin
					if (status.decrypt_mode) begin
						cmd.out_sel = OUT_STATUS;
						state_nxt   = ST_IDLE;
					end else begin
						cmd.out_sel = OUT_TAG_LO;
						state_nxt   = ST_EMIT2;
					end
				end
			end
			ST_EMIT2: begin
				if (out_free) begin
					cmd.out_sel = OUT_TAG_HI;
					state_nxt   = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			run_q     <= RUN_INIT;
			round_q   <= '0;
			open_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			run_q   <= run_nxt;
			round_q <= round_nxt;
			open_q  <= open_nxt;
			if (cmd.out_sel != OUT_NONE) begin
				out_vld_q <= 1'b1;
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	`ASSERT_IMPL(a_load_free, cmd.out_sel != OUT_NONE, !out_vld_q || res_ready, "output overwritten")
	`ASSERT_IMPL(a_round_range, state_q == ST_RUN, round_q <= ROUND_LAST, "round out of range")
	`ASSERT_IMPL(a_closed_emit, state_q == ST_EMIT1 || state_q == ST_EMIT2, !open_q, "message open at tag")
	`ASSERT_NEXT(a_run_hold, state_q == ST_RUN && round_q != ROUND_LAST, state_q == ST_RUN, "run cut short")

endmodule
